### design/gvsp_pkg.sv
`default_nettype none

package gvsp_pkg;

  // widths fixed by the stream format
  localparam int ID_W      = 16;
  localparam int DIM_W     = 16;
  localparam int IDX_W     = 11;
  localparam int SIZE_W    = 33;
  localparam int CFG_IDX_W = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  // packet format codes
  localparam logic [7:0] FMT_LEADER  = 8'h01;
  localparam logic [7:0] FMT_TRAILER = 8'h02;
  localparam logic [7:0] FMT_PAYLOAD = 8'h03;

  // header layout
  localparam logic [IDX_W-1:0] HEADER_BYTES = 11'd8;
  localparam logic [IDX_W-1:0] POS_FORMAT   = 11'd4;
  localparam logic [IDX_W-1:0] POS_ID_HI    = 11'd6;
  localparam logic [IDX_W-1:0] POS_ID_LO    = 11'd7;
  localparam logic [IDX_W-1:0] POS_WIDTH_HI = 11'd26;
  localparam logic [IDX_W-1:0] POS_WIDTH_LO = 11'd27;
  localparam logic [IDX_W-1:0] POS_HEIGHT_HI = 11'd30;
  localparam logic [IDX_W-1:0] POS_HEIGHT_LO = 11'd31;

  // frame receive phase, also reported on receive_state
  typedef enum logic [1:0] {
    PH_LEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_TRAILER = 2'd2
  } phase_t;

  typedef struct packed {
    logic [7:0] packet_byte;
    logic       packet_end;
  } in_item_t;

  typedef struct packed {
    logic        write_valid;
    logic [23:0] write_address;
    logic [7:0]  write_data;
    logic        frame_ready;
    logic [1:0]  receive_state;
  } out_item_t;

  // configuration seen by the parser
  typedef struct packed {
    logic [DIM_W-1:0]  image_width;
    logic [DIM_W-1:0]  image_height;
    logic [SIZE_W-1:0] frame_size;
  } cfg_t;

endpackage

`default_nettype wire

### design/gvsp_parser.sv
`default_nettype none

module gvsp_parser #(
  parameter int PACKET_DATA_BYTES = 1440,
  parameter int ADDR_BITS         = 24,
  parameter int MAX_PACKET_BYTES  = 2000
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                step,
  input  wire gvsp_pkg::in_item_t  item,
  input  wire gvsp_pkg::cfg_t      cfg,
  output gvsp_pkg::out_item_t      result
);
  import gvsp_pkg::*;

  localparam int MUL_W  = $clog2(PACKET_DATA_BYTES + 1);
  localparam int BASE_W = ID_W + MUL_W;
  localparam int FULL_W = BASE_W + 1;
  localparam int CMP_W  = (FULL_W > SIZE_W) ? FULL_W : SIZE_W;
  localparam int KEEP_W = (ADDR_BITS < 24) ? ADDR_BITS : 24;
  localparam logic [24:0] KEEP_LIM = 25'd1 << KEEP_W;
  localparam logic [23:0] OUT_MASK = 24'(KEEP_LIM - 25'd1);
  localparam logic [IDX_W-1:0] MAX_LEN = IDX_W'(MAX_PACKET_BYTES);
  localparam logic [BASE_W-1:0] PDB = BASE_W'(PACKET_DATA_BYTES);

  phase_t             phase;
  logic [ID_W-1:0]    last_id;
  logic [IDX_W-1:0]   byte_index;
  logic [7:0]         cur_fmt;
  logic [ID_W-1:0]    cur_id;
  logic [DIM_W-1:0]   leader_w;
  logic [DIM_W-1:0]   leader_h;
  logic               rejected;
  logic [BASE_W-1:0]  hi_part;
  logic [BASE_W-1:0]  base;

  phase_t             phase_next;
  logic [ID_W-1:0]    last_id_next;
  logic [IDX_W-1:0]   byte_index_next;
  logic [7:0]         cur_fmt_next;
  logic [ID_W-1:0]    cur_id_next;
  logic [DIM_W-1:0]   leader_w_next;
  logic [DIM_W-1:0]   leader_h_next;
  logic               rejected_next;
  logic [BASE_W-1:0]  hi_part_next;
  logic [BASE_W-1:0]  base_next;

  logic [7:0]         b;
  logic               in_range;
  logic               payload_now;
  logic [BASE_W-1:0]  lo_term;
  logic [BASE_W-1:0]  base_now;
  logic [BASE_W-1:0]  stop_base;
  logic [IDX_W-1:0]   len;
  logic [IDX_W-1:0]   len_off;
  logic [IDX_W-1:0]   k_off;
  logic [CMP_W-1:0]   addr;
  logic [CMP_W-1:0]   stop;
  logic [CMP_W-1:0]   size;
  logic               wv;
  logic               ready;

  assign b       = item.packet_byte;
  assign size    = CMP_W'(cfg.frame_size);
  assign in_range = byte_index < MAX_LEN;

  // payload base from the id bytes: high part at byte 6, finished at byte 7
  assign lo_term  = BASE_W'(b) * PDB;
  assign base_now = hi_part + lo_term - PDB;

  // byte address of this beat and end address of the packet
  assign k_off     = byte_index - HEADER_BYTES;
  assign addr      = CMP_W'(base) + CMP_W'(k_off);
  assign len       = in_range ? (byte_index + 11'd1) : MAX_LEN;
  assign len_off   = len - HEADER_BYTES;
  assign stop_base = (in_range && byte_index == POS_ID_LO) ? base_now : base;
  assign stop      = CMP_W'(stop_base) + CMP_W'(len_off);

  // header capture
  always_comb begin
    cur_fmt_next  = cur_fmt;
    cur_id_next   = cur_id;
    leader_w_next = leader_w;
    leader_h_next = leader_h;
    hi_part_next  = hi_part;
    base_next     = base;
    if (in_range) begin
      if (byte_index == POS_FORMAT)    cur_fmt_next = b;
      if (byte_index == POS_ID_HI) begin
        cur_id_next  = {b, 8'h00};
        hi_part_next = lo_term << 8;
      end
      if (byte_index == POS_ID_LO) begin
        cur_id_next = {cur_id[15:8], b};
        base_next   = base_now;
      end
      if (byte_index == POS_WIDTH_HI)  leader_w_next = {b, 8'h00};
      if (byte_index == POS_WIDTH_LO)  leader_w_next = {leader_w[15:8], b};
      if (byte_index == POS_HEIGHT_HI) leader_h_next = {b, 8'h00};
      if (byte_index == POS_HEIGHT_LO) leader_h_next = {leader_h[15:8], b};
    end
  end

  assign payload_now = (phase == PH_PAYLOAD) && (cur_fmt_next == FMT_PAYLOAD);

  // per-beat phase, id check, write decision and end-of-packet handling
  always_comb begin
    phase_next      = phase;
    last_id_next    = last_id;
    rejected_next   = rejected;
    byte_index_next = byte_index;
    wv              = 1'b0;
    ready           = 1'b0;

    if (in_range) begin
      byte_index_next = byte_index + 11'd1;
      if (payload_now) begin
        if (byte_index == POS_ID_LO) begin
          // forward gap drops the frame, repeats and backward ids are taken
          if ({1'b0, cur_id_next} > ({1'b0, last_id} + 17'd1)) begin
            phase_next = PH_LEADER;
          end else begin
            last_id_next = cur_id_next;
            if (cur_id_next == '0) rejected_next = 1'b1;
          end
        end else if (byte_index >= HEADER_BYTES && !rejected) begin
          if (addr < size) wv = 1'b1;
          else             rejected_next = 1'b1;
        end
      end
    end

    if (item.packet_end) begin
      if (len >= HEADER_BYTES) begin
        unique case (phase_next)
          PH_LEADER: begin
            if (cur_fmt_next == FMT_LEADER && leader_w_next == cfg.image_width &&
                leader_h_next == cfg.image_height) begin
              last_id_next = cur_id_next;
              phase_next   = PH_PAYLOAD;
            end
          end
          PH_PAYLOAD: begin
            if (cur_fmt_next == FMT_PAYLOAD) begin
              if (rejected_next)     phase_next = PH_LEADER;
              else if (stop > size)  phase_next = PH_LEADER;
              else if (stop == size) phase_next = PH_TRAILER;
            end
          end
          PH_TRAILER: begin
            ready      = (cur_fmt_next == FMT_TRAILER);
            phase_next = PH_LEADER;
          end
          default: phase_next = PH_LEADER;
        endcase
      end
      byte_index_next = '0;
      rejected_next   = 1'b0;
    end
  end

  // result of this beat
  always_comb begin
    result.write_valid   = wv;
    result.write_address = wv ? (addr[23:0] & OUT_MASK) : 24'h0;
    result.write_data    = wv ? b : 8'h00;
    result.frame_ready   = ready;
    result.receive_state = phase_next;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_LEADER;
      last_id    <= '0;
      byte_index <= '0;
      cur_fmt    <= '0;
      cur_id     <= '0;
      leader_w   <= '0;
      leader_h   <= '0;
      rejected   <= 1'b0;
    end else if (step) begin
      phase      <= phase_next;
      last_id    <= last_id_next;
      byte_index <= byte_index_next;
      rejected   <= rejected_next;
      if (item.packet_end) begin
        cur_fmt  <= '0;
        cur_id   <= '0;
        leader_w <= '0;
        leader_h <= '0;
      end else begin
        cur_fmt  <= cur_fmt_next;
        cur_id   <= cur_id_next;
        leader_w <= leader_w_next;
        leader_h <= leader_h_next;
      end
    end
  end

  // payload base, only read after it is written in the same packet
  always_ff @(posedge clk) begin
    if (step) begin
      hi_part <= hi_part_next;
      base    <= base_next;
    end
  end

endmodule

`default_nettype wire

### design/gvsp_frame_reassembler.sv
// GVSP frame reassembler: rebuilds one 16-bit image frame from stream datagrams.
// in channel (in_valid/in_ready/in_data): one datagram byte per beat, packet_end
//   on the last byte. Leader, payload and trailer packets drive a three-phase
//   frame machine; payload bytes come out as frame buffer writes.
// out channel (out_valid/out_ready/out_data): exactly one result beat per input
//   beat, carrying the write strobe, address and data, the frame_ready pulse and
//   the receive phase after that byte.
// cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): index 0 image width,
//   index 1 image height; always ready. The user must write it only while the
//   stream is idle; the block does not enforce this. Results are registered.
// Throughput is one byte per cycle while in_ready is high; the per-byte path
//   is one address add and compare against the frame size registered from cfg.
// In the cycle after a config write in_ready is low while the frame size
//   register picks up the new product.
// A two-entry output (register plus skid) keeps in_ready independent of
//   out_ready: when the receiver stalls one more beat is taken, then in_ready
//   drops until the skid entry drains.
// Synchronous reset returns the machine to awaiting a leader, clears both
//   config registers and empties the output.
`default_nettype none

module gvsp_frame_reassembler #(
  parameter int PACKET_DATA_BYTES = 1440,
  parameter int ADDR_BITS         = 24,
  parameter int MAX_PACKET_BYTES  = 2000
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output      logic                                in_ready,
  input  wire gvsp_pkg::in_item_t                  in_data,
  output      logic                                out_valid,
  input  wire logic                                out_ready,
  output      gvsp_pkg::out_item_t                 out_data,
  input  wire logic                                cfg_valid,
  output      logic                                cfg_ready,
  input  wire logic [gvsp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [gvsp_pkg::DIM_W-1:0]          cfg_data
);
  import gvsp_pkg::*;

  logic [DIM_W-1:0]   image_width;
  logic [DIM_W-1:0]   image_height;
  logic [2*DIM_W-1:0] pixel_count;
  logic               cfg_hold;
  cfg_t               cfg;

  out_item_t          result;
  out_item_t          skid_data;
  logic               skid_valid;
  logic               in_accept;
  logic               out_free;

  assign cfg_ready = 1'b1;
  assign in_ready  = !skid_valid && !cfg_hold;
  assign in_accept = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;

  // config registers and registered frame size
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= '0;
      image_height <= '0;
      pixel_count  <= '0;
      cfg_hold     <= 1'b0;
    end else begin
      cfg_hold    <= cfg_valid;
      pixel_count <= image_width * image_height;
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_IMAGE_WIDTH:  image_width  <= cfg_data;
          REG_IMAGE_HEIGHT: image_height <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  assign cfg.image_width  = image_width;
  assign cfg.image_height = image_height;
  assign cfg.frame_size   = {pixel_count, 1'b0};

  gvsp_parser #(
    .PACKET_DATA_BYTES (PACKET_DATA_BYTES),
    .ADDR_BITS         (ADDR_BITS),
    .MAX_PACKET_BYTES  (MAX_PACKET_BYTES)
  ) u_parser (
    .clk    (clk),
    .rst    (rst),
    .step   (in_accept),
    .item   (in_data),
    .cfg    (cfg),
    .result (result)
  );

  // output register with skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      out_valid  <= skid_valid || in_accept;
      skid_valid <= 1'b0;
    end else if (in_accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid)     out_data <= skid_data;
      else if (in_accept) out_data <= result;
    end else if (in_accept) begin
      skid_data <= result;
    end
  end

endmodule

`default_nettype wire

### bench/tb_gvsp_frame_reassembler.sv
`default_nettype none

module tb_gvsp_frame_reassembler;
  timeunit 1ns;
  timeprecision 1ps;

  import gvsp_pkg::*;

  localparam int PKT_DATA    = 1440;
  localparam int PKT_MAX     = 2000;
  localparam int CYCLE_LIMIT = 600000;
  localparam int N_SETTINGS  = 9;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_IMAGE_WIDTH;
  logic [DIM_W-1:0]     cfg_data = '0;

  gvsp_frame_reassembler #(
    .PACKET_DATA_BYTES(PKT_DATA),
    .ADDR_BITS(24),
    .MAX_PACKET_BYTES(PKT_MAX)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // datagram bytes waiting to be sent, and the results they should produce
  in_item_t  datagram_bytes[$];
  out_item_t predicted_writes[$];

  int unsigned mismatches = 0;
  int unsigned bytes_queued = 0;
  int unsigned bytes_sent = 0;
  int unsigned frames_committed = 0;
  int unsigned buffer_writes = 0;
  int unsigned cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_left = 0;
  logic        hold_arm = 1'b0;
  logic        hold_done = 1'b0;

  // shadow of the frame machine
  logic [DIM_W-1:0] m_width = '0;
  logic [DIM_W-1:0] m_height = '0;
  phase_t           m_phase = PH_LEADER;
  logic [ID_W-1:0]  m_last_id = '0;
  int unsigned      m_index = 0;
  logic [7:0]       m_fmt = '0;
  logic [ID_W-1:0]  m_id = '0;
  logic [DIM_W-1:0] m_lw = '0;
  logic [DIM_W-1:0] m_lh = '0;
  logic             m_reject = 1'b0;

  // advance the shadow machine by one byte and return the expected result
  function automatic out_item_t reassemble_byte(input in_item_t b);
    out_item_t       r;
    int unsigned     len;
    longint unsigned size, base, addr, stop;
    r = '0;
    size = 64'(m_width) * 64'(m_height) * 64'd2;
    if (m_index < PKT_MAX) begin
      case (m_index)
        POS_FORMAT:    m_fmt = b.packet_byte;
        POS_ID_HI:     m_id = {b.packet_byte, 8'h00};
        POS_ID_LO:     m_id = {m_id[15:8], b.packet_byte};
        POS_WIDTH_HI:  m_lw = {b.packet_byte, 8'h00};
        POS_WIDTH_LO:  m_lw = {m_lw[15:8], b.packet_byte};
        POS_HEIGHT_HI: m_lh = {b.packet_byte, 8'h00};
        POS_HEIGHT_LO: m_lh = {m_lh[15:8], b.packet_byte};
        default: ;
      endcase
      base = (64'(m_id) - 64'd1) * PKT_DATA;
      if (m_phase == PH_PAYLOAD && m_fmt == FMT_PAYLOAD) begin
        if (m_index == POS_ID_LO) begin
          // forward gap drops the frame, repeats and backward ids pass
          if (m_id != m_last_id + 1 && m_id > m_last_id) begin
            m_phase = PH_LEADER;
          end else begin
            m_last_id = m_id;
            if (m_id == 0) m_reject = 1'b1;
          end
        end else if (m_index >= HEADER_BYTES && !m_reject) begin
          addr = base + 64'(m_index - HEADER_BYTES);
          if (addr < size) begin
            r.write_valid   = 1'b1;
            r.write_data    = b.packet_byte;
            r.write_address = addr[23:0];
          end else begin
            m_reject = 1'b1;
          end
        end
      end
      m_index++;
      len = m_index;
    end else begin
      len = PKT_MAX;
    end

    // end of datagram: phase transitions
    if (b.packet_end) begin
      if (len >= HEADER_BYTES) begin
        base = (64'(m_id) - 64'd1) * PKT_DATA;
        case (m_phase)
          PH_LEADER: begin
            if (m_fmt == FMT_LEADER && m_lw == m_width && m_lh == m_height) begin
              m_last_id = m_id;
              m_phase = PH_PAYLOAD;
            end
          end
          PH_PAYLOAD: begin
            if (m_fmt == FMT_PAYLOAD) begin
              stop = base + 64'(len - HEADER_BYTES);
              if (m_reject || stop > size) m_phase = PH_LEADER;
              else if (stop == size) m_phase = PH_TRAILER;
            end
          end
          default: begin
            if (m_fmt == FMT_TRAILER) r.frame_ready = 1'b1;
            m_phase = PH_LEADER;
          end
        endcase
      end
      m_index = 0;
      m_fmt = '0;
      m_id = '0;
      m_lw = '0;
      m_lh = '0;
      m_reject = 1'b0;
    end
    r.receive_state = m_phase;
    return r;
  endfunction

  // sender: one beat per handshake, random idle cycles
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predicted_writes.push_back(reassemble_byte(in_data));
        if (predicted_writes[$].write_valid) buffer_writes++;
        if (predicted_writes[$].frame_ready) frames_committed++;
        bytes_sent++;
      end
      if (!in_valid || in_ready) begin
        if (datagram_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data <= datagram_bytes.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, started once
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_arm && !hold_done) begin
      hold_left <= 300;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected 0x%0h actual 0x%0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // receiver: compare each result beat with the oldest prediction
  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (predicted_writes.size() == 0) begin
          $display("%0t: unexpected result beat, expected none actual %p", $time, out_data);
          mismatches++;
        end else begin
          want = predicted_writes.pop_front();
          check_field("write_valid", want.write_valid, out_data.write_valid);
          check_field("write_address", want.write_address, out_data.write_address);
          check_field("write_data", want.write_data, out_data.write_data);
          check_field("frame_ready", want.frame_ready, out_data.frame_ready);
          check_field("receive_state", want.receive_state, out_data.receive_state);
        end
      end
      out_ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout at cycle %0d, %0d results outstanding", cycles, predicted_writes.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // queue one datagram; dims only go into leaders
  task automatic put_packet(input logic [7:0] fmt, input logic [15:0] id,
                            input int unsigned len,
                            input logic [15:0] lw = '0, input logic [15:0] lh = '0);
    in_item_t it;
    for (int unsigned k = 0; k < len; k++) begin
      it.packet_byte = 8'($urandom);
      it.packet_end = (k == len - 1);
      case (k)
        POS_FORMAT:    it.packet_byte = fmt;
        POS_ID_HI:     it.packet_byte = id[15:8];
        POS_ID_LO:     it.packet_byte = id[7:0];
        POS_WIDTH_HI:  if (fmt == FMT_LEADER) it.packet_byte = lw[15:8];
        POS_WIDTH_LO:  if (fmt == FMT_LEADER) it.packet_byte = lw[7:0];
        POS_HEIGHT_HI: if (fmt == FMT_LEADER) it.packet_byte = lh[15:8];
        POS_HEIGHT_LO: if (fmt == FMT_LEADER) it.packet_byte = lh[7:0];
        default: ;
      endcase
      datagram_bytes.push_back(it);
      bytes_queued++;
    end
  endtask

  // one frame attempt: leader, payload packets, trailer, with occasional faults
  task automatic put_frame(input logic [15:0] w, input logic [15:0] h);
    longint unsigned size;
    int unsigned     lead_id, id, n_chunks, data_len, fault;
    logic [15:0]     lw;
    size = 64'(w) * 64'(h) * 64'd2;
    fault = $urandom_range(0, 11);
    lw = w;
    if ($urandom_range(0, 7) == 0) lw = lw ^ (16'd1 << $urandom_range(0, 15));
    if (size > 64'd5760) lead_id = $urandom_range(0, 65530);
    else if ($urandom_range(0, 7) == 0) lead_id = $urandom_range(0, 65535);
    else lead_id = $urandom_range(0, 3);

    // stray short datagram before the leader
    if (fault == 5) put_packet(8'($urandom), 16'($urandom), $urandom_range(1, 7));
    if ($urandom_range(0, 7) == 0)
      put_packet(FMT_LEADER, lead_id, $urandom_range(8, 31), lw, h);
    else
      put_packet(FMT_LEADER, lead_id, $urandom_range(32, 40), lw, h);

    // huge frames never complete: a few payloads, then a gap to drop
    if (size > 64'd5760) begin
      id = lead_id + 1;
      repeat ($urandom_range(2, 4)) begin
        put_packet(FMT_PAYLOAD, id, 8 + $urandom_range(0, 40));
        if ($urandom_range(0, 1) == 1) id++;
      end
      put_packet(FMT_PAYLOAD, id + 2, 8 + $urandom_range(0, 8));
      return;
    end

    n_chunks = (size + PKT_DATA - 1) / PKT_DATA;
    if (n_chunks == 0) n_chunks = 1;
    for (int unsigned c = 1; c <= n_chunks; c++) begin
      data_len = (c < n_chunks) ? PKT_DATA : int'(size) - (c - 1) * PKT_DATA;
      if (fault == 6) put_packet($urandom_range(4, 255), c, 8 + $urandom_range(0, 20));
      if (data_len > 0 && $urandom_range(0, 2) == 0)
        put_packet(FMT_PAYLOAD, c, 8 + $urandom_range(0, data_len - 1));
      if (c == n_chunks && fault == 0)
        put_packet(FMT_PAYLOAD, c + 5, data_len + 8);
      else if (c == n_chunks && fault == 1)
        put_packet(FMT_PAYLOAD, 16'd0, data_len + 8);
      else if (c == n_chunks && fault == 2)
        put_packet(FMT_PAYLOAD, c, data_len + 8 + $urandom_range(1, 4));
      else if (c == 1 && n_chunks > 1)
        put_packet(FMT_PAYLOAD, c, PKT_MAX + 5);
      else
        put_packet(FMT_PAYLOAD, c, data_len + 8);
    end

    if (fault == 4) return;
    if (fault == 3) put_packet($urandom_range(3, 255), 16'($urandom), $urandom_range(8, 16));
    else put_packet(FMT_TRAILER, 16'($urandom), $urandom_range(8, 16));
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_IMAGE_WIDTH) m_width = val;
    else if (idx == REG_IMAGE_HEIGHT) m_height = val;
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (datagram_bytes.size() != 0 || in_valid || predicted_writes.size() != 0);
    repeat (3) @(posedge clk);
  endtask

  logic [15:0] plan_w [N_SETTINGS] = '{3, 1, 8, 16'hFFFF, 0, 1000, 16, 16'hFFFF, 2};
  logic [15:0] plan_h [N_SETTINGS] = '{2, 1, 4, 16'hFFFF, 16'hFFFF, 1, 3, 0, 5};

  initial begin
    int unsigned start;
    int unsigned mode;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // registers at reset: short packet, short leader, empty payload, trailer
    put_packet(8'($urandom), 16'($urandom), 3);
    put_packet(FMT_LEADER, 16'd0, 8);
    put_packet(FMT_PAYLOAD, 16'd1, 8);
    put_packet(FMT_TRAILER, 16'($urandom), 8);

    for (int p = 0; p < N_SETTINGS; p++) begin
      wait_drained();
      write_reg(REG_IMAGE_WIDTH, plan_w[p]);
      write_reg(REG_IMAGE_HEIGHT, plan_h[p]);
      mode = p % 4;
      send_idle_pct = (mode == 1) ? 64 : (mode == 3) ? 37 : 0;
      recv_stall_pct = (mode == 2) ? 64 : (mode == 3) ? 37 : 0;
      if (p == 0) hold_arm <= 1'b1;
      start = bytes_queued;
      while (bytes_queued - start < 200) put_frame(plan_w[p], plan_h[p]);
    end

    wait_drained();
    repeat (10) @(posedge clk);
    $display("sent %0d datagram bytes across %0d register settings and four idle patterns",
             bytes_sent, N_SETTINGS);
    $display("checked %0d buffer writes and %0d committed frames",
             buffer_writes, frames_committed);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire
